>>> sv/xo256_pkg.sv
// ----------------------------------------------------------------------------
// xo256_pkg
// Shared types, operation codes and default seed words for the generator.
// ----------------------------------------------------------------------------
package xo256_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned NWords = 4;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    OP_GENERATE = 3'd0,
    OP_ADVANCE  = 3'd1,
    OP_SEED     = 3'd2,
    OP_DEFAULT  = 3'd3,
    OP_XOR_ADD  = 3'd4,
    OP_LOAD     = 3'd5
  } func_e;

  // One registered operation: code plus the four operand words.
  typedef struct packed {
    func_e                  func;
    logic [NWords-1:0][WordW-1:0] words;
  } item_t;

  localparam word_t DefaultWord0 = 64'd12323456;
  localparam word_t DefaultWord1 = 64'd54321;
  localparam word_t DefaultWord2 = 64'h0000_0000_a02b_4c7d;
  localparam word_t DefaultWord3 = 64'h0000_0000_94a3_f7ee;

  localparam int unsigned ShiftT   = 17;
  localparam int unsigned RotState = 45;
  localparam int unsigned RotOut   = 23;

  function automatic word_t rotl(input word_t x, input int unsigned k);
    rotl = (x << k) | (x >> (WordW - k));
  endfunction

endpackage

>>> sv/xo256_state.sv
// ----------------------------------------------------------------------------
// xo256_state
// Holds the four state words, computes one operation's result and the next
// state in a single pass, and commits the state when the item is taken.
// ----------------------------------------------------------------------------
module xo256_state
  import xo256_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output word_t value_o
);

  word_t s_q [NWords];
  word_t s_d [NWords];
  word_t adv [NWords];
  word_t t2, t3, t1, t0;

  // One xoshiro256 step
  always_comb begin
    t2 = s_q[2] ^ s_q[0];
    t3 = s_q[3] ^ s_q[1];
    t1 = s_q[1] ^ t2;
    t0 = s_q[0] ^ t3;
    adv[0] = t0;
    adv[1] = t1;
    adv[2] = t2 ^ (s_q[1] << ShiftT);
    adv[3] = rotl(t3, RotState);
  end

  always_comb begin
    for (int i = 0; i < NWords; i++) begin
      s_d[i] = s_q[i];
    end
    value_o = '0;
    case (item_i.func)
      OP_GENERATE: begin
        value_o = rotl(s_q[0] + s_q[3], RotOut) + s_q[0];
        s_d = adv;
      end
      OP_ADVANCE: begin
        value_o = adv[3];
        s_d = adv;
      end
      OP_SEED: begin
        s_d[0] = item_i.words[0];
        s_d[1] = '0;
        s_d[2] = '0;
        s_d[3] = '0;
      end
      OP_DEFAULT: begin
        s_d[0] = DefaultWord0;
        s_d[1] = DefaultWord1;
        s_d[2] = DefaultWord2;
        s_d[3] = DefaultWord3;
      end
      OP_XOR_ADD: begin
        for (int i = 0; i < NWords; i++) begin
          s_d[i] = s_q[i] ^ item_i.words[i];
        end
      end
      OP_LOAD: begin
        for (int i = 0; i < NWords; i++) begin
          s_d[i] = item_i.words[i];
        end
      end
      default: begin
        // unused codes: state holds, result zero
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q[0] <= DefaultWord0;
      s_q[1] <= DefaultWord1;
      s_q[2] <= DefaultWord2;
      s_q[3] <= DefaultWord3;
    end else if (en_i) begin
      s_q <= s_d;
    end
  end

endmodule

>>> sv/xoshiro256pp_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256pp_generator
// xoshiro256++ generator with seed, reload, XOR-combine and load operations.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                         tuser
//  s_axis    in   word0..word3 (256 bits)       func (3 bits)
//  m_axis    out  value (64 bits)               -
//
//  One item per cycle sustained while results are taken; an accepted item is
//  held in the input register, then takes one pass through the state logic
//  into the result register, where its result goes valid.
//  The state words update in the same cycle the item leaves the input
//  register, so items chain with no bubble.
//  Reset loads the default seed words and empties both registers.
//  A stalled result holds the pipe; input tready drops only when both the
//  input and result registers are full and the result is not being taken.
//
module xoshiro256pp_generator
  import xo256_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // word0 [63:0], word1, word2, word3 [255:192]
  input  logic [2:0]   s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata    // value
);

  // input register
  item_t in_q;
  logic  in_valid_q;
  // result register
  word_t out_q;
  logic  out_valid_q;

  logic  fire;      // item moves from input register into result register
  logic  take_in;
  word_t value;
  item_t in_item;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_item.func = func_e'(s_axis_tuser);
    for (int i = 0; i < NWords; i++) begin
      in_item.words[i] = s_axis_tdata[i*WordW +: WordW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_item;
    end
  end

  xo256_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .item_i  (in_q),
    .value_o (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> sv/xo256_checker.sv
// ----------------------------------------------------------------------------
// xo256_checker
// Port-level checks for the generator, bound to the top level.
// ----------------------------------------------------------------------------
module xo256_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  // stalled result stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input backpressure only comes from a pending result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // a result appearing on an empty output came from an accepted item that passed through the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input item");

endmodule

bind xoshiro256pp_generator xo256_checker u_xo256_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/xoshiro256pp_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xoshiro256pp_generator_test
// Self-checking bench: random and directed operations stream into the
// generator under random idling on both sides. A local model of the 256-bit
// state predicts every 64-bit result, which is checked in arrival order.
// ----------------------------------------------------------------------------
module xoshiro256pp_generator_test
  import xo256_pkg::*;
();

  // Codes the block does not define; they must leave the state alone.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam int unsigned RandomOps   = 1830;
  localparam int unsigned LongStall   = 80;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic         pause;  // hold this item until every result is back
    logic [2:0]   code;
    logic [255:0] words;  // word0 in the low bits
  } op_item_t;

  typedef struct packed {
    logic [2:0] code;
    word_t      value;
  } want_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;   // word0 [63:0], word1, word2, word3 [255:192]
  logic [2:0]   s_axis_tuser;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // value

  op_item_t    item_q[$];
  want_t       value_q[$];
  word_t       xs_state[4];

  bit          in_taken;
  bit          out_taken;
  bit          tx_eager;
  bit          rx_eager;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned rx_count;
  int unsigned err_count;
  int unsigned shown_count;

  xoshiro256pp_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // State model
  // --------------------------------------------------------------------------
  function automatic word_t rot64(input word_t x, input int unsigned k);
    logic [127:0] dbl;
    dbl = {x, x} << k;
    return dbl[127:64];
  endfunction

  // One xoshiro256 step; returns the new word 3.
  function automatic word_t step_state();
    word_t t;
    t = xs_state[1] << ShiftT;
    xs_state[2] ^= xs_state[0];
    xs_state[3] ^= xs_state[1];
    xs_state[1] ^= xs_state[2];
    xs_state[0] ^= xs_state[3];
    xs_state[2] ^= t;
    xs_state[3] = rot64(xs_state[3], RotState);
    return xs_state[3];
  endfunction

  function automatic void load_defaults();
    xs_state[0] = DefaultWord0;
    xs_state[1] = DefaultWord1;
    xs_state[2] = DefaultWord2;
    xs_state[3] = DefaultWord3;
  endfunction

  // Applies one operation to the model and returns the value it yields.
  function automatic word_t next_output(input logic [2:0] code, input logic [255:0] data);
    word_t w[4];
    word_t v;
    for (int i = 0; i < 4; i++) w[i] = data[64*i +: 64];
    v = '0;
    case (code)
      OP_GENERATE: begin
        v = rot64(xs_state[0] + xs_state[3], RotOut) + xs_state[0];
        void'(step_state());
      end
      OP_ADVANCE: v = step_state();
      OP_SEED: begin
        xs_state[0] = w[0];
        xs_state[1] = '0;
        xs_state[2] = '0;
        xs_state[3] = '0;
      end
      OP_DEFAULT: load_defaults();
      OP_XOR_ADD: for (int i = 0; i < 4; i++) xs_state[i] ^= w[i];
      OP_LOAD:    for (int i = 0; i < 4; i++) xs_state[i] = w[i];
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly full-range words, with a share of all-zero and all-one words.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_op(input logic [2:0] code, input word_t w0, input word_t w1,
                         input word_t w2, input word_t w3, input logic pause);
    op_item_t it;
    it.pause = pause;
    it.code  = code;
    it.words = {w3, w2, w1, w0};
    item_q.push_back(it);
  endtask

  task automatic push_rand(input logic [2:0] code, input logic pause);
    push_op(code, rand_word(), rand_word(), rand_word(), rand_word(), pause);
  endtask

  // --------------------------------------------------------------------------
  // Sender: offers queued items at the falling edge, random gaps per item,
  // with stretches of back-to-back items.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic     nxt_valid;
    op_item_t it;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid && !in_taken;
      if (in_taken) begin
        in_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) tx_eager = !tx_eager;
        tx_wait = tx_eager ? 0 : $urandom_range(0, 7);
      end
      if (!nxt_valid) begin
        if (tx_wait != 0) begin
          tx_wait--;
        end else if (item_q.size() != 0 && !(item_q[0].pause && value_q.size() != 0)) begin
          it = item_q.pop_front();
          s_axis_tdata <= it.words;
          s_axis_tuser <= it.code;
          nxt_valid = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per result, plus two long holds that back the
  // pipe up into the input side.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) rx_eager = !rx_eager;
        if (rx_count == 300 || rx_count == 1200) rx_wait = LongStall;
        else rx_wait = rx_eager ? 0 : $urandom_range(0, 7);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the result first, then predicts the item taken at this
  // edge, so a result never meets its own prediction in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    want_t w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        rx_count++;
        if (value_q.size() == 0) begin
          err_count++;
          if (shown_count < MaxReported) begin
            shown_count++;
            $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
          end
        end else begin
          w = value_q.pop_front();
          if (m_axis_tdata !== w.value) begin
            err_count++;
            if (shown_count < MaxReported) begin
              shown_count++;
              $display("%0t: op %0d value exp %h got %h", $realtime, w.code, w.value,
                       m_axis_tdata);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        w.code  = s_axis_tuser;
        w.value = next_output(s_axis_tuser, s_axis_tdata);
        value_q.push_back(w);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned r;
    logic [2:0]  code;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    in_taken      = 1'b0;
    out_taken     = 1'b0;
    tx_eager      = 1'b0;
    rx_eager      = 1'b0;
    tx_wait       = 0;
    rx_wait       = 0;
    rx_count      = 0;
    err_count     = 0;
    shown_count   = 0;
    load_defaults();

    // Directed: outputs from the reset state, zero state, extreme words,
    // every operation and both spare codes.
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_ADVANCE, 1'b0);
    push_rand(OP_ADVANCE, 1'b0);
    push_op(OP_SEED, '0, '1, '1, '1, 1'b0);          // all-zero state
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_ADVANCE, 1'b0);
    push_op(OP_SEED, '1, '0, '0, '0, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_DEFAULT, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_op(OP_LOAD, '1, '1, '1, '1, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_ADVANCE, 1'b0);
    push_op(OP_XOR_ADD, '1, '1, '1, '1, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_XOR_ADD, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_op(OP_LOAD, '0, '0, '0, '0, 1'b0);
    push_rand(OP_GENERATE, 1'b0);
    push_rand(OP_LOAD, 1'b0);
    push_rand(OpSpare6, 1'b0);
    push_rand(OpSpare7, 1'b0);
    push_rand(OP_GENERATE, 1'b0);

    // Random: mostly generate/advance between state changes; every 450
    // items the sender waits for the pipe to drain.
    for (int n = 0; n < RandomOps; n++) begin
      r = $urandom_range(0, 99);
      if (r < 60)      code = OP_GENERATE;
      else if (r < 75) code = OP_ADVANCE;
      else if (r < 81) code = OP_SEED;
      else if (r < 85) code = OP_DEFAULT;
      else if (r < 91) code = OP_XOR_ADD;
      else if (r < 96) code = OP_LOAD;
      else if (r < 98) code = OpSpare6;
      else             code = OpSpare7;
      push_rand(code, (n % 450) == 0);
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || s_axis_tvalid || value_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
